// ----- rtl/pue_pkg.sv -----
// Shared types, constants and fixed-point helpers for the particle update engine.
// No dependencies.
`timescale 1ns / 1ps

package pue_pkg;

   localparam int MAX_PARTICLES_DEF = 64;

   // configuration register indexes
   localparam logic [1:0] CSR_GRAVITY     = 2'd0;
   localparam logic [1:0] CSR_BOUND_X     = 2'd1;
   localparam logic [1:0] CSR_BOUND_Y     = 2'd2;
   localparam logic [1:0] CSR_RESTITUTION = 2'd3;

   localparam logic signed [15:0] GRAVITY_RST     = 16'sd0;
   localparam logic [14:0]        BOUND_X_RST     = 15'd12800;
   localparam logic [14:0]        BOUND_Y_RST     = 15'd12800;
   localparam logic [7:0]         RESTITUTION_RST = 8'd205;

   // result kinds
   localparam logic [1:0] KIND_ACK    = 2'd0;
   localparam logic [1:0] KIND_REPORT = 2'd1;
   localparam logic [1:0] KIND_EMPTY  = 2'd2;

   localparam logic       MODE_SPAWN = 1'b0;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic [23:0]        colour;
      logic [15:0]        life_left;
      logic [15:0]        life_init;
      logic [7:0]         alpha;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // -v*restitution/256 rounded down, saturated; prod = v*restitution
   function automatic logic signed [15:0] bounce(input logic signed [24:0] prod);
      logic signed [25:0] neg;
      neg = -{prod[24], prod};
      return sat16(neg[25:8]);
   endfunction

endpackage

// ----- rtl/particle_update_engine.sv -----
// Particle update engine: one particle store in RAM, an update sequencer and
// the result register. Depends on pue_pkg, pue_ram and pue_alpha_div.
`timescale 1ns / 1ps

// A spawn item yields one acknowledge. A tick item makes two passes over the
// particle RAM through its single read port: an update pass with a read, four
// arithmetic stages and the 8-bit serial alpha divider per surviving particle
// (the divider skips its bit steps when alpha saturates at 255) and a read and
// the four arithmetic stages per expiring one, then a report pass that reads
// and sends each survivor, waiting out any output stalls. Items are taken only
// while the sequencer is idle and the result register can be loaded.

module particle_update_engine #(
   parameter int MAX_PARTICLES = pue_pkg::MAX_PARTICLES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // dt, spawn_x, spawn_y, spawn_vx, spawn_vy, spawn_red, spawn_green,
   // spawn_blue, spawn_life
   input  logic [119:0] req_tdata,
   input  logic         req_tuser,   // mode
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x, pos_y, red, green, blue, alpha, live_count, dropped
   output logic [71:0]  rsp_tdata,
   output logic [1:0]   rsp_tuser,   // kind
   output logic         rsp_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_wen,
   input  logic [1:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);
   import pue_pkg::*;

   localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int CW = $clog2(MAX_PARTICLES + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PARTICLES);

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_GRAV  = 10'b0000000010,
      ST_FETCH = 10'b0000000100,
      ST_LOAD  = 10'b0000001000,
      ST_MUL   = 10'b0000010000,
      ST_POS   = 10'b0000100000,
      ST_BNC   = 10'b0001000000,
      ST_DIV   = 10'b0010000000,
      ST_EREAD = 10'b0100000000,
      ST_EOUT  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic signed [15:0] gravity_ff;
   logic [14:0]        bound_x_ff, bound_y_ff;
   logic [7:0]         restitution_ff;

   // request fields
   logic [15:0]        req_dt, req_life;
   logic signed [15:0] req_x, req_y, req_vx, req_vy;
   logic [23:0]        req_col;

   assign req_dt   = req_tdata[15:0];
   assign req_x    = req_tdata[31:16];
   assign req_y    = req_tdata[47:32];
   assign req_vx   = req_tdata[63:48];
   assign req_vy   = req_tdata[79:64];
   assign req_col  = req_tdata[103:80];
   assign req_life = req_tdata[119:104];

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] src_ff, src_in;

   logic [15:0]        dt_ff, dt_in;
   logic signed [16:0] gdv_ff, gdv_in;
   entry_type          ent_ff, ent_in;
   logic signed [15:0] px_ff, px_in, py_ff, py_in, vx_ff, vx_in, vy_ff, vy_in;
   logic signed [16:0] mx_ff, mx_in, my_ff, my_in;
   logic signed [24:0] bx_ff, bx_in, by_ff, by_in;
   logic signed [24:0] rem_ff, rem_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [71:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_kind_ff, rsp_kind_in;
   logic        rsp_last_ff, rsp_last_in;
   logic        slot_free;

   // RAM
   logic            ram_we, ram_re;
   logic [AW-1:0]   ram_waddr, ram_raddr;
   entry_type       ram_wdata, ram_rdata;
   logic [ENTRY_W-1:0] ram_rbits;

   // divider
   logic       div_start, div_done;
   logic [7:0] div_alpha;

   logic accept;
   logic full;

   // arithmetic intermediates
   logic signed [32:0] gprod;
   logic signed [32:0] mxp, myp;
   logic signed [24:0] rem_new;
   logic               x_out, y_out, dead;
   logic [23:0]        life_up;

   pue_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PARTICLES)) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rbits)
   );
   assign ram_rdata = entry_type'(ram_rbits);

   pue_alpha_div u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .rem  (rem_ff[23:0]),
      .init (ent_ff.life_init),
      .done (div_done),
      .alpha(div_alpha)
   );

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign full       = count_ff >= MAX_CNT;

   assign gprod   = gravity_ff * $signed({1'b0, dt_ff});
   assign mxp     = vx_ff * $signed({1'b0, dt_ff});
   assign myp     = vy_ff * $signed({1'b0, dt_ff});
   assign rem_new = $signed({1'b0, ram_rdata.life_left, 8'd0}) - $signed({9'd0, dt_ff});
   assign x_out   = px_ff < 16'sd0 || px_ff > $signed({1'b0, bound_x_ff});
   assign y_out   = py_ff < 16'sd0 || py_ff > $signed({1'b0, bound_y_ff});
   assign dead    = rem_ff[24] || rem_ff == 25'sd0;
   assign life_up = rem_ff[23:0] + 24'd255;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      src_in       = src_ff;
      dt_in        = dt_ff;
      gdv_in       = gdv_ff;
      ent_in       = ent_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = count_ff[AW-1:0];
      ram_wdata    = '{pos_x: req_x, pos_y: req_y, vel_x: req_vx, vel_y: req_vy,
                       colour: req_col, life_left: req_life, life_init: req_life,
                       alpha: ALPHA_OPAQUE};
      ram_re       = 1'b0;
      ram_raddr    = src_ff[AW-1:0];
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == MODE_SPAWN) begin
                  ram_we = !full;
                  if (!full) begin
                     count_in = count_ff + CW'(1);
                  end
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_ACK;
                  rsp_last_in  = 1'b1;
                  rsp_data_in  = {full, 7'(count_in), ALPHA_OPAQUE, req_col,
                                  req_y, req_x};
               end else begin
                  dt_in    = req_dt;
                  cnt_in   = count_ff;
                  idx_in   = '0;
                  src_in   = '0;
                  state_in = ST_GRAV;
               end
            end
         end
         ST_GRAV: begin
            gdv_in   = gprod[32:16];
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            if (idx_ff >= cnt_ff) begin
               count_in = cnt_ff;
               idx_in   = '0;
               state_in = ST_EREAD;
            end else begin
               ram_re   = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            ent_in   = ram_rdata;
            px_in    = ram_rdata.pos_x;
            py_in    = ram_rdata.pos_y;
            vx_in    = ram_rdata.vel_x;
            vy_in    = sat16({{2{ram_rdata.vel_y[15]}}, ram_rdata.vel_y} +
                             {gdv_ff[16], gdv_ff});
            rem_in   = rem_new;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            mx_in    = mxp[32:16];
            my_in    = myp[32:16];
            state_in = ST_POS;
         end
         ST_POS: begin
            px_in    = sat16({{2{px_ff[15]}}, px_ff} + {mx_ff[16], mx_ff});
            py_in    = sat16({{2{py_ff[15]}}, py_ff} + {my_ff[16], my_ff});
            bx_in    = vx_ff * $signed({1'b0, restitution_ff});
            by_in    = vy_ff * $signed({1'b0, restitution_ff});
            state_in = ST_BNC;
         end
         ST_BNC: begin
            if (x_out) begin
               vx_in = bounce(bx_ff);
               px_in = px_ff[15] ? 16'sd0 : $signed({1'b0, bound_x_ff});
            end
            if (y_out) begin
               vy_in = bounce(by_ff);
               py_in = py_ff[15] ? 16'sd0 : $signed({1'b0, bound_y_ff});
            end
            if (dead) begin
               // last particle moves into this slot and is processed here
               cnt_in   = cnt_ff - CW'(1);
               src_in   = cnt_ff - CW'(1);
               state_in = ST_FETCH;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               ram_we    = 1'b1;
               ram_waddr = idx_ff[AW-1:0];
               ram_wdata = '{pos_x: px_ff, pos_y: py_ff, vel_x: vx_ff, vel_y: vy_ff,
                             colour: ent_ff.colour, life_left: life_up[23:8],
                             life_init: ent_ff.life_init, alpha: div_alpha};
               idx_in    = idx_ff + CW'(1);
               src_in    = idx_ff + CW'(1);
               state_in  = ST_FETCH;
            end
         end
         ST_EREAD: begin
            if (cnt_ff == '0) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_EMPTY;
                  rsp_last_in  = 1'b1;
                  rsp_data_in  = '0;
                  state_in     = ST_IDLE;
               end
            end else begin
               ram_re    = 1'b1;
               ram_raddr = idx_ff[AW-1:0];
               state_in  = ST_EOUT;
            end
         end
         ST_EOUT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_REPORT;
               rsp_last_in  = idx_ff == cnt_ff - CW'(1);
               rsp_data_in  = {1'b0, 7'(cnt_ff), ram_rdata.alpha, ram_rdata.colour,
                               ram_rdata.pos_y, ram_rdata.pos_x};
               idx_in       = idx_ff + CW'(1);
               state_in     = rsp_last_in ? ST_IDLE : ST_EREAD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         cnt_ff         <= '0;
         idx_ff         <= '0;
         src_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         gravity_ff     <= GRAVITY_RST;
         bound_x_ff     <= BOUND_X_RST;
         bound_y_ff     <= BOUND_Y_RST;
         restitution_ff <= RESTITUTION_RST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         src_ff       <= src_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            unique case (csr_addr)
               CSR_GRAVITY:     gravity_ff     <= csr_wdata;
               CSR_BOUND_X:     bound_x_ff     <= csr_wdata[14:0];
               CSR_BOUND_Y:     bound_y_ff     <= csr_wdata[14:0];
               CSR_RESTITUTION: restitution_ff <= csr_wdata[7:0];
               default:         ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      dt_ff       <= dt_in;
      gdv_ff      <= gdv_in;
      ent_ff      <= ent_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/pue_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module pue_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/pue_alpha_div.sv -----
// Restoring divider for alpha = min(255, rem*255 / (init*256)), one bit a cycle.
// Depends on pue_pkg.
`timescale 1ns / 1ps

module pue_alpha_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [23:0] rem,
   input  logic [15:0] init,
   output logic        done,
   output logic [7:0]  alpha
);
   import pue_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [2:0]  step_ff, step_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] den_ff, den_in;
   logic [7:0]  quo_ff, quo_in;
   logic [31:0] num;
   logic        ge;

   assign num = {rem, 8'd0} - {8'd0, rem};
   assign ge  = rem_ff >= den_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         rem_in  = num;
         den_in  = {1'b0, init, 15'd0};
         step_in = '0;
         // quotient of 256 or more (or zero divisor) saturates
         if (num >= {init, 16'd0}) begin
            quo_in  = ALPHA_OPAQUE;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - den_ff;
         end
         quo_in  = {quo_ff[6:0], ge};
         den_in  = den_ff >> 1;
         step_in = step_ff + 3'd1;
         if (step_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done  = done_ff;
   assign alpha = quo_ff;

endmodule

// ----- test/testbench.sv -----
// Self-checking bench for particle_update_engine: random and directed spawn and tick
// items, an in-bench particle store predictor and field-by-field result checks.
// Depends on pue_pkg and the engine RTL.
`timescale 1ns / 1ps

module testbench;
   import pue_pkg::*;

   typedef struct {
      logic               mode;
      logic [15:0]        dt;
      logic signed [15:0] sx, sy, svx, svy;
      logic [7:0]         red, green, blue;
      logic [15:0]        life;
   } particle_req_type;

   typedef struct {
      logic [1:0]         kind;
      logic signed [15:0] pos_x, pos_y;
      logic [7:0]         red, green, blue, alpha;
      logic [6:0]         live;
      logic               dropped, last;
   } particle_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [119:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [71:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_wen = 1'b0;
   logic [1:0]   csr_addr = '0;
   logic [15:0]  csr_wdata = '0;

   particle_update_engine DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   particle_req_type pending_items[$];
   particle_rsp_type expected_rsps[$];
   int idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;

   // predictor state
   int          p_x[64], p_y[64], v_x[64], v_y[64];
   logic [23:0] p_col[64];
   longint      life_left[64], life_init[64];
   int          live_n = 0;
   int          grav = 0, bnd_x = 12800, bnd_y = 12800, rest = 205;

   function automatic void add_item(particle_req_type it);
      pending_items.insert(pending_items.size(), it);
   endfunction

   function automatic void expect_rsp(particle_rsp_type r);
      expected_rsps.insert(expected_rsps.size(), r);
   endfunction

   function automatic int sat_q12(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
   endfunction

   function automatic int bounce_vel(int v);
      longint p;
      p = -longint'(v) * rest;
      return sat_q12(p >>> 8);
   endfunction

   task automatic predict_particles(particle_req_type it);
      particle_rsp_type r;
      particle_rsp_type reps[$];
      int     i, vx, vy, px, py, last_i;
      longint dt, rem, a;
      dt = longint'(it.dt);
      r = '{default: '0};
      if (it.mode == MODE_SPAWN) begin
         r.kind = KIND_ACK;
         r.pos_x = it.sx; r.pos_y = it.sy;
         r.red = it.red; r.green = it.green; r.blue = it.blue;
         r.alpha = ALPHA_OPAQUE;
         r.dropped = (live_n >= 64);
         if (!r.dropped) begin
            p_x[live_n] = int'(it.sx); p_y[live_n] = int'(it.sy);
            v_x[live_n] = int'(it.svx); v_y[live_n] = int'(it.svy);
            p_col[live_n] = {it.red, it.green, it.blue};
            life_left[live_n] = longint'(it.life); life_init[live_n] = longint'(it.life);
            live_n++;
         end
         r.live = 7'(live_n);
         r.last = 1'b1;
         expect_rsp(r);
         return;
      end
      i = 0;
      while (i < live_n) begin
         vx = v_x[i];
         vy = sat_q12(longint'(v_y[i]) + ((longint'(grav) * dt) >>> 16));
         px = sat_q12(longint'(p_x[i]) + ((longint'(vx) * dt) >>> 16));
         py = sat_q12(longint'(p_y[i]) + ((longint'(vy) * dt) >>> 16));
         rem = (life_left[i] << 8) - dt;
         if (px < 0 || px > bnd_x) begin
            vx = bounce_vel(vx);
            px = (px < 0) ? 0 : bnd_x;
         end
         if (py < 0 || py > bnd_y) begin
            vy = bounce_vel(vy);
            py = (py < 0) ? 0 : bnd_y;
         end
         if (rem <= 0) begin
            // expired: last particle moves into this slot and is processed next
            last_i = live_n - 1;
            p_x[i] = p_x[last_i]; p_y[i] = p_y[last_i];
            v_x[i] = v_x[last_i]; v_y[i] = v_y[last_i];
            p_col[i] = p_col[last_i];
            life_left[i] = life_left[last_i]; life_init[i] = life_init[last_i];
            live_n--;
            continue;
         end
         a = 255;
         if (life_init[i] != 0) begin
            a = (rem * 255) / (life_init[i] << 8);
            if (a > 255) a = 255;
         end
         p_x[i] = px; p_y[i] = py; v_x[i] = vx; v_y[i] = vy;
         life_left[i] = (rem + 255) >>> 8;
         r = '{default: '0};
         r.kind = KIND_REPORT;
         r.pos_x = 16'(px); r.pos_y = 16'(py);
         {r.red, r.green, r.blue} = p_col[i];
         r.alpha = a[7:0];
         reps.insert(reps.size(), r);
         i++;
      end
      if (reps.size() == 0) begin
         r = '{default: '0};
         r.kind = KIND_EMPTY;
         r.last = 1'b1;
         expect_rsp(r);
         return;
      end
      foreach (reps[k]) begin
         reps[k].live = 7'(live_n);
         reps[k].last = (k == reps.size() - 1);
         expect_rsp(reps[k]);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset && (!req_tvalid || req_tready)) begin
         if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_tvalid <= 1'b1;
            req_tuser  <= pending_items[0].mode;
            req_tdata  <= {pending_items[0].life, pending_items[0].blue,
                           pending_items[0].green, pending_items[0].red,
                           pending_items[0].svy, pending_items[0].svx,
                           pending_items[0].sy, pending_items[0].sx, pending_items[0].dt};
            void'(pending_items.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // monitor: predict on accepted input, then check accepted output
   always @(posedge clock) begin
      particle_req_type it;
      particle_rsp_type got, want;
      if (!reset && req_tvalid && req_tready) begin
         it.mode = req_tuser;
         {it.life, it.blue, it.green, it.red, it.svy, it.svx, it.sy, it.sx, it.dt} =
            req_tdata;
         predict_particles(it);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         {got.dropped, got.live, got.alpha, got.blue, got.green, got.red,
          got.pos_y, got.pos_x} = rsp_tdata;
         got.last = rsp_tlast;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: kind %0d x %0d y %0d", got.kind, got.pos_x,
                        got.pos_y);
         end else begin
            want = expected_rsps.pop_front();
            if (got.kind !== want.kind || got.pos_x !== want.pos_x ||
                got.pos_y !== want.pos_y || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue ||
                got.alpha !== want.alpha || got.live !== want.live ||
                got.dropped !== want.dropped || got.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp kind %0d x %0d y %0d rgb %h %h %h a %0d ",
                            "live %0d drop %0d last %0d / got kind %0d x %0d y %0d ",
                            "rgb %h %h %h a %0d live %0d drop %0d last %0d"},
                           want.kind, want.pos_x, want.pos_y, want.red, want.green,
                           want.blue, want.alpha, want.live, want.dropped, want.last,
                           got.kind, got.pos_x, got.pos_y, got.red, got.green,
                           got.blue, got.alpha, got.live, got.dropped, got.last);
            end
         end
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_wen <= 1'b1; csr_addr <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_GRAVITY:     grav = int'(signed'(val));
         CSR_BOUND_X:     bnd_x = int'(val[14:0]);
         CSR_BOUND_Y:     bnd_y = int'(val[14:0]);
         CSR_RESTITUTION: rest = int'(val[7:0]);
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_regs(logic [15:0] g, logic [15:0] bx, logic [15:0] by,
                           logic [15:0] rs);
      write_reg(CSR_GRAVITY, g);
      write_reg(CSR_BOUND_X, bx);
      write_reg(CSR_BOUND_Y, by);
      write_reg(CSR_RESTITUTION, rs);
   endtask

   function automatic particle_req_type make_spawn(int x, int y, int vx, int vy,
                                                   logic [23:0] col, int life);
      particle_req_type it;
      it.mode = MODE_SPAWN;
      it.dt = 16'($urandom);
      it.sx = 16'(x); it.sy = 16'(y); it.svx = 16'(vx); it.svy = 16'(vy);
      {it.red, it.green, it.blue} = col;
      it.life = 16'(life);
      return it;
   endfunction

   function automatic particle_req_type make_tick(int dt);
      particle_req_type it;
      it = make_spawn($urandom, $urandom, $urandom, $urandom, 24'($urandom), $urandom);
      it.mode = !MODE_SPAWN;
      it.dt = 16'(dt);
      return it;
   endfunction

   function automatic particle_req_type random_item(int tick_pct);
      int x, y, life;
      if ($urandom_range(99) < tick_pct)
         return make_tick($urandom_range(3) == 0 ? $urandom_range(65535)
                                                 : $urandom_range(8000));
      x = $urandom_range(4) == 0 ? int'(signed'(16'($urandom))) : $urandom_range(bnd_x);
      y = $urandom_range(4) == 0 ? int'(signed'(16'($urandom))) : $urandom_range(bnd_y);
      life = $urandom_range(3) == 0 ? $urandom_range(1, 65535) : $urandom_range(1, 1500);
      return make_spawn(x, y, int'(signed'(16'($urandom))), int'(signed'(16'($urandom))),
                        24'($urandom), life);
   endfunction

   // waits for the phase to drain; the block is then idle
   task automatic drain;
      while (pending_items.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty tick, field extremes, zero and maximum dt, short lives
      add_item(make_tick(100));
      add_item(make_spawn(-32768, 32767, 32767, -32768, 24'h000000, 1));
      add_item(make_spawn(32767, -32768, -32768, 32767, 24'hFFFFFF, 65535));
      add_item(make_spawn(0, 0, 0, 0, 24'h123456, 256));
      add_item(make_spawn(12800, 12800, -16, 16, 24'hA5A55A, 2));
      add_item(make_tick(0));
      add_item(make_tick(65535));
      add_item(make_spawn(100, 100, 1000, -1000, 24'h00FF00, 300));
      add_item(make_tick(65535));
      add_item(make_tick(1));
      add_item(make_tick(65535));
      add_item(make_tick(65535));
      add_item(make_tick(65535));
      drain();

      set_regs(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
      idle_pct = 83; stall_pct = 0;
      repeat (16) add_item(random_item(30));
      drain();

      // fill the store past full, then tick a crowded store
      set_regs(16'h8000, 16'h7FFF, 16'hFFFF, 16'h00FF);
      idle_pct = 0; stall_pct = 83;
      repeat (67) add_item(random_item(0));
      repeat (4) add_item(make_tick($urandom_range(2000)));
      drain();

      set_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      idle_pct = 10; stall_pct = 10;
      repeat (16) add_item(random_item(35));
      drain();

      idle_pct = 0; stall_pct = 0;
      add_item(make_tick(65535));
      repeat (4) add_item(random_item(40));
      drain();

      if (mismatches == 0) begin
         $display("particle_update_engine verification clean");
      end else begin
         $display("particle_update_engine verification failed");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("particle_update_engine verification failed");
      $finish;
   end

endmodule
